### sv/tlapq_pkg.sv
// Package for the three-level aged priority queue.
// Types, field widths, request/status codes and default sizes. No dependencies.
`default_nettype none
package tlapq_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int NUM_LEVELS_DEF = 3;

   localparam int ID_W   = 16;
   localparam int LVL_W  = 2;
   localparam int TIME_W = 38;
   localparam int ST_W   = 3;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REPRIO = 2'd1,
      REQ_SERVE  = 2'd2,
      REQ_SEARCH = 2'd3
   } req_code_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_BAD_LEVEL = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [LVL_W-1:0]  lvl;
      logic [TIME_W-1:0] tm;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_FIX
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic start;     // latch request, rewind sweep
      logic run;       // advance sweep
      logic fix_mode;  // sweep rewrites ranks
      logic decide;    // commit result of scan
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sweep_done;
      logic need_fix;
      logic rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

### sv/tlapq_if.sv
// Channel interfaces for the aged priority queue: request and response beats.
// Depends on tlapq_pkg for field widths.
`default_nettype none
interface tlapq_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     req_type;
   logic [tlapq_pkg::ID_W-1:0]     ticket_id;
   logic [tlapq_pkg::LVL_W-1:0]    level;
   logic [tlapq_pkg::TIME_W-1:0]   created;
   modport source (output valid, req_type, ticket_id, level, created, input ready);
   modport sink   (input valid, req_type, ticket_id, level, created, output ready);
endinterface

interface tlapq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tlapq_pkg::ST_W-1:0]     status;
   logic [tlapq_pkg::ID_W-1:0]     out_id;
   logic [tlapq_pkg::LVL_W-1:0]    out_level;
   logic [tlapq_pkg::TIME_W-1:0]   out_created;
   modport source (output valid, status, out_id, out_level, out_created, input ready);
   modport sink   (input valid, status, out_id, out_level, out_created, output ready);
endinterface
`default_nettype wire

### sv/three_level_aged_priority_queue.sv
// A request beat is answered after one scan sweep of the entry RAM (one read
//   per cycle) and a decide step, which waits while the response register is full.
// Insert/search/no-op need only that sweep; a successful serve or level change
//   adds a second rank-fix sweep. The next request is taken only after both.
// Reset: synchronous; all entries invalid, count zero, no response pending.
`default_nettype none
module three_level_aged_priority_queue #(
   parameter int CAPACITY   = tlapq_pkg::CAPACITY_DEF,
   parameter int NUM_LEVELS = tlapq_pkg::NUM_LEVELS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tlapq_req_if.sink   req_ch,
   tlapq_rsp_if.source rsp_ch
);
   // Controller sequences the sweeps; the datapath holds entries in one RAM
   // word each ({id, level, time, arrival rank}) with valid bits in flops.
   // The scan sweep finds the id match, the lowest free slot and the oldest
   // entry of the highest level in one pass. The fix sweep closes the rank
   // gap after a removal and re-ranks a moved entry as the newest arrival.
   // A finished beat sits in the response register while a new request is
   // taken; decide stalls only if that register is still full.
   tlapq_pkg::ctl_cmd_type   cmd;
   tlapq_pkg::dp_status_type dp_status;

   tlapq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .dp_status(dp_status),
      .cmd      (cmd)
   );

   tlapq_dpath #(.CAPACITY(CAPACITY), .NUM_LEVELS(NUM_LEVELS)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .req_type   (req_ch.req_type),
      .ticket_id  (req_ch.ticket_id),
      .level      (req_ch.level),
      .created    (req_ch.created),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .status     (rsp_ch.status),
      .out_id     (rsp_ch.out_id),
      .out_level  (rsp_ch.out_level),
      .out_created(rsp_ch.out_created)
   );
endmodule
`default_nettype wire

### sv/tlapq_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module tlapq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### sv/tlapq_ctrl.sv
// Controller FSM: accept, scan sweep, decide, rank-fix sweep.
// Depends on tlapq_pkg.
`default_nettype none
module tlapq_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire tlapq_pkg::dp_status_type dp_status,
   output tlapq_pkg::ctl_cmd_type        cmd
);
   tlapq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlapq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tlapq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = tlapq_pkg::S_SCAN;
            end
         end
         tlapq_pkg::S_SCAN: begin
            cmd.run = 1'b1;
            if (dp_status.sweep_done) begin
               state_in = tlapq_pkg::S_DECIDE;
            end
         end
         tlapq_pkg::S_DECIDE: begin
            // wait for the response register to free up
            if (dp_status.rsp_free) begin
               cmd.decide = 1'b1;
               state_in   = dp_status.need_fix ? tlapq_pkg::S_FIX : tlapq_pkg::S_IDLE;
            end
         end
         tlapq_pkg::S_FIX: begin
            cmd.run      = 1'b1;
            cmd.fix_mode = 1'b1;
            if (dp_status.sweep_done) begin
               state_in = tlapq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tlapq_pkg::S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

### sv/tlapq_dpath.sv
// Datapath: entry RAM, valid bits, sweep pipeline, match/free/oldest search,
// rank fix-up and response register. Depends on tlapq_pkg and tlapq_ram.
`default_nettype none
module tlapq_dpath #(
   parameter int CAPACITY   = tlapq_pkg::CAPACITY_DEF,
   parameter int NUM_LEVELS = tlapq_pkg::NUM_LEVELS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tlapq_pkg::ctl_cmd_type        cmd,
   output tlapq_pkg::dp_status_type           dp_status,
   input  wire logic [1:0]                    req_type,
   input  wire logic [tlapq_pkg::ID_W-1:0]    ticket_id,
   input  wire logic [tlapq_pkg::LVL_W-1:0]   level,
   input  wire logic [tlapq_pkg::TIME_W-1:0]  created,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [tlapq_pkg::ST_W-1:0]         status,
   output logic [tlapq_pkg::ID_W-1:0]         out_id,
   output logic [tlapq_pkg::LVL_W-1:0]        out_level,
   output logic [tlapq_pkg::TIME_W-1:0]       out_created
);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int RANK_W = IDX_W;
   localparam int WORD_W = tlapq_pkg::ENTRY_W + RANK_W;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   // latched request
   tlapq_pkg::req_code_type           op_ff, op_in;
   logic [tlapq_pkg::ID_W-1:0]        id_ff, id_in;
   logic [tlapq_pkg::LVL_W-1:0]       lvl_ff, lvl_in;
   logic [tlapq_pkg::TIME_W-1:0]      tm_ff, tm_in;

   logic [CAPACITY-1:0]               valid_ff, valid_in;
   logic [CNT_W-1:0]                  count_ff, count_in;

   // sweep pipeline
   logic [CNT_W-1:0]                  addr_ff, addr_in;
   logic                              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                  rd_idx_ff, rd_idx_in;

   // scan results
   logic                              hit_ff, hit_in;
   logic [IDX_W-1:0]                  hit_idx_ff, hit_idx_in;
   tlapq_pkg::entry_type              hit_ent_ff, hit_ent_in;
   logic [RANK_W-1:0]                 hit_rank_ff, hit_rank_in;
   logic                              free_ff, free_in;
   logic [IDX_W-1:0]                  free_idx_ff, free_idx_in;
   logic                              best_ff, best_in;
   logic [IDX_W-1:0]                  best_idx_ff, best_idx_in;
   tlapq_pkg::entry_type              best_ent_ff, best_ent_in;
   logic [RANK_W-1:0]                 best_rank_ff, best_rank_in;

   // fix sweep parameters
   logic [RANK_W-1:0]                 fix_rank_ff, fix_rank_in;
   logic                              tgt_en_ff, tgt_en_in;
   logic [IDX_W-1:0]                  tgt_idx_ff, tgt_idx_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   tlapq_pkg::status_type             st_ff, st_in;
   tlapq_pkg::entry_type              rsp_ent_ff, rsp_ent_in;

   // RAM ports
   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr;
   logic [WORD_W-1:0]                 wr_data;
   logic [WORD_W-1:0]                 rd_data;

   tlapq_pkg::entry_type              rd_ent;
   logic [RANK_W-1:0]                 rd_rank;
   logic                              rd_live;
   logic                              older;
   logic                              bad_lvl;
   logic [CNT_W-1:0]                  count_m1;
   tlapq_pkg::status_type             st_dec;

   tlapq_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(addr_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   assign rd_ent   = tlapq_pkg::entry_type'(rd_data[WORD_W-1 -: tlapq_pkg::ENTRY_W]);
   assign rd_rank  = rd_data[RANK_W-1:0];
   assign rd_live  = rd_vld_ff && valid_ff[rd_idx_ff];
   assign bad_lvl  = int'(lvl_ff) >= NUM_LEVELS;
   assign count_m1 = count_ff - CNT_W'(1);

   // candidate beats current best: higher level, then older time, then earlier rank
   always_comb begin
      if (!best_ff) begin
         older = 1'b1;
      end else if (rd_ent.lvl != best_ent_ff.lvl) begin
         older = rd_ent.lvl > best_ent_ff.lvl;
      end else if (rd_ent.tm != best_ent_ff.tm) begin
         older = rd_ent.tm < best_ent_ff.tm;
      end else begin
         older = rd_rank < best_rank_ff;
      end
   end

   // outcome of the scan
   always_comb begin
      st_dec = tlapq_pkg::ST_OK;
      case (op_ff)
         tlapq_pkg::REQ_INSERT: begin
            if (bad_lvl) begin
               st_dec = tlapq_pkg::ST_BAD_LEVEL;
            end else if (hit_ff) begin
               st_dec = tlapq_pkg::ST_DUPLICATE;
            end else if (!free_ff) begin
               st_dec = tlapq_pkg::ST_FULL;
            end
         end
         tlapq_pkg::REQ_REPRIO: begin
            if (bad_lvl) begin
               st_dec = tlapq_pkg::ST_BAD_LEVEL;
            end else if (!hit_ff) begin
               st_dec = tlapq_pkg::ST_NOT_FOUND;
            end
         end
         tlapq_pkg::REQ_SERVE: begin
            if (!best_ff) begin
               st_dec = tlapq_pkg::ST_NOT_FOUND;
            end
         end
         tlapq_pkg::REQ_SEARCH: begin
            if (!hit_ff) begin
               st_dec = tlapq_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            st_dec = tlapq_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   always_comb begin
      dp_status.sweep_done = (addr_ff == CAP_C) && !rd_vld_ff;
      dp_status.rsp_free   = !rsp_valid_ff || rsp_ready;
      dp_status.need_fix   = (st_dec == tlapq_pkg::ST_OK) &&
                             ((op_ff == tlapq_pkg::REQ_SERVE) ||
                              ((op_ff == tlapq_pkg::REQ_REPRIO) && (hit_ent_ff.lvl != lvl_ff)));
   end

   always_comb begin
      op_in        = op_ff;
      id_in        = id_ff;
      lvl_in       = lvl_ff;
      tm_in        = tm_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = addr_ff[IDX_W-1:0];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_ent_in   = hit_ent_ff;
      hit_rank_in  = hit_rank_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      best_ent_in  = best_ent_ff;
      best_rank_in = best_rank_ff;
      fix_rank_in  = fix_rank_ff;
      tgt_en_in    = tgt_en_ff;
      tgt_idx_in   = tgt_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      st_in        = st_ff;
      rsp_ent_in   = rsp_ent_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_data      = {rd_ent, rd_rank};

      if (cmd.start) begin
         op_in   = tlapq_pkg::req_code_type'(req_type);
         id_in   = ticket_id;
         lvl_in  = level;
         tm_in   = created;
         addr_in = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
         best_in = 1'b0;
      end

      if (cmd.run) begin
         if (addr_ff != CAP_C) begin
            rd_vld_in = 1'b1;
            addr_in   = addr_ff + CNT_W'(1);
         end
         if (!cmd.fix_mode && rd_vld_ff) begin
            if (rd_live && (rd_ent.id == id_ff) && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = rd_idx_ff;
               hit_ent_in  = rd_ent;
               hit_rank_in = rd_rank;
            end
            if (!valid_ff[rd_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = rd_idx_ff;
            end
            if (rd_live && older) begin
               best_in      = 1'b1;
               best_idx_in  = rd_idx_ff;
               best_ent_in  = rd_ent;
               best_rank_in = rd_rank;
            end
         end
         if (cmd.fix_mode && rd_live) begin
            if (tgt_en_ff && (rd_idx_ff == tgt_idx_ff)) begin
               // moved entry rejoins as the latest arrival in its new level
               wr_en   = 1'b1;
               wr_data = {rd_ent.id, lvl_ff, rd_ent.tm, count_m1[RANK_W-1:0]};
            end else if (rd_rank > fix_rank_ff) begin
               wr_en   = 1'b1;
               wr_data = {rd_ent, rd_rank - RANK_W'(1)};
            end
         end
      end

      if (cmd.decide) begin
         addr_in      = '0;
         rsp_valid_in = 1'b1;
         st_in        = st_dec;
         rsp_ent_in   = '0;
         tgt_en_in    = 1'b0;
         if (st_dec == tlapq_pkg::ST_OK) begin
            case (op_ff)
               tlapq_pkg::REQ_INSERT: begin
                  wr_en                 = 1'b1;
                  wr_addr               = free_idx_ff;
                  wr_data               = {id_ff, lvl_ff, tm_ff, count_ff[RANK_W-1:0]};
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + CNT_W'(1);
               end
               tlapq_pkg::REQ_REPRIO: begin
                  fix_rank_in = hit_rank_ff;
                  tgt_en_in   = 1'b1;
                  tgt_idx_in  = hit_idx_ff;
               end
               tlapq_pkg::REQ_SERVE: begin
                  rsp_ent_in            = best_ent_ff;
                  valid_in[best_idx_ff] = 1'b0;
                  count_in              = count_m1;
                  fix_rank_in           = best_rank_ff;
               end
               tlapq_pkg::REQ_SEARCH: begin
                  rsp_ent_in = hit_ent_ff;
               end
               default: begin
                  rsp_ent_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         best_ff      <= 1'b0;
         tgt_en_ff    <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         best_ff      <= best_in;
         tgt_en_ff    <= tgt_en_in;
      end
      op_ff        <= op_in;
      id_ff        <= id_in;
      lvl_ff       <= lvl_in;
      tm_ff        <= tm_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_ent_ff   <= hit_ent_in;
      hit_rank_ff  <= hit_rank_in;
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ent_ff  <= best_ent_in;
      best_rank_ff <= best_rank_in;
      fix_rank_ff  <= fix_rank_in;
      tgt_idx_ff   <= tgt_idx_in;
      st_ff        <= st_in;
      rsp_ent_ff   <= rsp_ent_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign status      = st_ff;
   assign out_id      = rsp_ent_ff.id;
   assign out_level   = rsp_ent_ff.lvl;
   assign out_created = rsp_ent_ff.tm;
endmodule
`default_nettype wire

### sv/tlapq_checker.sv
// Port-level checker for the aged priority queue, with its bind.
// Depends on tlapq_pkg and three_level_aged_priority_queue.
`default_nettype none
module tlapq_props (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [tlapq_pkg::ST_W-1:0]    status,
   input wire logic [tlapq_pkg::ID_W-1:0]    out_id,
   input wire logic [tlapq_pkg::LVL_W-1:0]   out_level,
   input wire logic [tlapq_pkg::TIME_W-1:0]  out_created
);
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status <= tlapq_pkg::ST_FULL))
      else $error("status code out of range");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status != tlapq_pkg::ST_OK)) |->
         ((out_id == '0) && (out_level == '0) && (out_created == '0)))
      else $error("payload not cleared on failed request");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(out_id)))
      else $error("stalled response beat changed");
endmodule

bind three_level_aged_priority_queue tlapq_props u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .status     (rsp_ch.status),
   .out_id     (rsp_ch.out_id),
   .out_level  (rsp_ch.out_level),
   .out_created(rsp_ch.out_created)
);
`default_nettype wire
